>>> hw/rtl/pfr_pkg.sv
// ============================================================================
// Page frame replacement package
// Shared constants, types and a helper function for the replacement unit.
// ============================================================================
package pfr_pkg;

    localparam int FRAMES     = 64;
    localparam int FRAME_W    = $clog2(FRAMES);
    localparam int CNT_W      = $clog2(FRAMES + 1);
    localparam int ADDR_W     = 32;
    localparam int PAGE_SHIFT = 12;
    localparam int PAGE_W     = ADDR_W - PAGE_SHIFT;
    localparam int STAMP_W    = 32;
    localparam int TOTAL_W    = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;

    localparam logic [CFG_IDX_W-1:0]  CFG_REPL_MODE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0]  CFG_FRAMES_IN_USE = 2'd1;
    localparam logic [CFG_DATA_W-1:0] FRAMES_RESET      = 7'd64;

    typedef enum logic {
        MODE_LRU  = 1'b0,
        MODE_FIFO = 1'b1
    } t_mode;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DECIDE
    } t_state;

    typedef struct packed {
        logic [PAGE_W-1:0]  page;
        logic [STAMP_W-1:0] stamp;
    } t_frame_entry;

    typedef struct packed {
        logic               vld;
        logic [FRAME_W-1:0] idx;
        logic               frame_valid;
        t_frame_entry       entry;
    } t_scan_beat;

    typedef struct packed {
        logic               found;
        logic [FRAME_W-1:0] hit_idx;
        logic [FRAME_W-1:0] best_idx;
        logic [PAGE_W-1:0]  best_page;
        logic [PAGE_W-1:0]  probe_page;
    } t_scan_res;

    function automatic logic [CNT_W-1:0] f_capacity(input logic [CFG_DATA_W-1:0] n);
        logic [CNT_W-1:0] c;
        if (n == '0) begin
            c = CNT_W'(1);
        end else if (n > CFG_DATA_W'(FRAMES)) begin
            c = CNT_W'(FRAMES);
        end else begin
            c = CNT_W'(n);
        end
        return c;
    endfunction

endpackage

>>> hw/rtl/pfr_frame_ram.sv
// ============================================================================
// Frame table memory
// One write port and one registered read port holding page and stamp per frame.
// ============================================================================
module pfr_frame_ram (
    input  logic                          i_clk,
    input  logic                          i_we,
    input  logic [pfr_pkg::FRAME_W-1:0]   i_waddr,
    input  pfr_pkg::t_frame_entry         i_wdata,
    input  logic [pfr_pkg::FRAME_W-1:0]   i_raddr,
    output pfr_pkg::t_frame_entry         o_rdata
);

    pfr_pkg::t_frame_entry r_mem [pfr_pkg::FRAMES];
    pfr_pkg::t_frame_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> hw/rtl/pfr_scan.sv
// ============================================================================
// Frame scan unit
// Compares one frame per cycle: tag match, oldest stamp and probe capture.
// ============================================================================
module pfr_scan (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  pfr_pkg::t_scan_beat           i_beat,
    input  logic [pfr_pkg::PAGE_W-1:0]    i_target,
    input  logic [pfr_pkg::CNT_W-1:0]     i_cap,
    input  logic [pfr_pkg::FRAME_W-1:0]   i_probe_idx,
    output pfr_pkg::t_scan_res            o_res
);

    logic                           r_found;
    logic [pfr_pkg::FRAME_W-1:0]    r_hit_idx;
    logic                           r_best_set;
    logic [pfr_pkg::FRAME_W-1:0]    r_best_idx;
    logic [pfr_pkg::STAMP_W-1:0]    r_best_stamp;
    logic [pfr_pkg::PAGE_W-1:0]     r_best_page;
    logic [pfr_pkg::PAGE_W-1:0]     r_probe_page;

    logic w_match;
    logic w_in_range;
    logic w_older;

    assign w_match    = i_beat.vld && i_beat.frame_valid && (i_beat.entry.page == i_target);
    assign w_in_range = pfr_pkg::CNT_W'(i_beat.idx) < i_cap;
    assign w_older    = !r_best_set || (i_beat.entry.stamp < r_best_stamp);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found    <= 1'b0;
            r_best_set <= 1'b0;
        end else if (i_start) begin
            r_found    <= 1'b0;
            r_best_set <= 1'b0;
        end else if (i_beat.vld) begin
            if (w_match && !r_found) begin
                r_found <= 1'b1;
            end
            if (w_in_range && w_older) begin
                r_best_set <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_beat.vld) begin
            if (w_match && !r_found) begin
                r_hit_idx <= i_beat.idx;
            end
            if (w_in_range && w_older) begin
                r_best_idx   <= i_beat.idx;
                r_best_stamp <= i_beat.entry.stamp;
                r_best_page  <= i_beat.entry.page;
            end
            if (i_beat.idx == i_probe_idx) begin
                r_probe_page <= i_beat.entry.page;
            end
        end
    end

    always_comb begin
        o_res.found      = r_found;
        o_res.hit_idx    = r_hit_idx;
        o_res.best_idx   = r_best_idx;
        o_res.best_page  = r_best_page;
        o_res.probe_page = r_probe_page;
    end

endmodule

>>> hw/rtl/page_frame_replacement_unit.sv
// ============================================================================
// Page frame replacement unit
// Resolves memory accesses against resident frames with LRU or FIFO victims.
// ============================================================================
//  channel  | handshake            | payload
//  ---------+----------------------+---------------------------------------
//  access   | i_valid / o_ready    | i_address, i_is_write
//  result   | o_valid / i_ready    | o_hit ... o_total_disk_writes
//  config   | i_cfg_we             | i_cfg_idx, i_cfg_data
//
//  Each item is accepted, every frame table entry is read in turn, the read
//  register is drained and the item is committed; a new access is accepted
//  only once the unit is idle again. Reset clears all frames and totals. A held
//  result delays the commit of the next item until the result is taken.
// ============================================================================
module page_frame_replacement_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic [pfr_pkg::ADDR_W-1:0]         i_address,
    input  logic                               i_is_write,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic                               o_hit,
    output logic                               o_disk_read,
    output logic                               o_disk_write,
    output logic [pfr_pkg::FRAME_W-1:0]        o_frame_index,
    output logic                               o_evicted_valid,
    output logic [pfr_pkg::PAGE_W-1:0]         o_evicted_page,
    output logic [pfr_pkg::TOTAL_W-1:0]        o_total_hits,
    output logic [pfr_pkg::TOTAL_W-1:0]        o_total_disk_reads,
    output logic [pfr_pkg::TOTAL_W-1:0]        o_total_disk_writes,
    input  logic                               i_cfg_we,
    input  logic [pfr_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [pfr_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    pfr_pkg::t_state                   r_state;
    pfr_pkg::t_state                   n_state;
    pfr_pkg::t_mode                    r_mode;
    logic [pfr_pkg::CFG_DATA_W-1:0]    r_frames_in_use;
    logic [pfr_pkg::FRAME_W-1:0]       r_idx;
    logic                              r_rd_vld;
    logic [pfr_pkg::FRAME_W-1:0]       r_rd_idx;
    logic [pfr_pkg::PAGE_W-1:0]        r_page;
    logic                              r_is_write;
    logic [pfr_pkg::FRAMES-1:0]        r_frame_valid;
    logic [pfr_pkg::FRAMES-1:0]        r_frame_dirty;
    logic [pfr_pkg::STAMP_W-1:0]       r_access_clock;
    logic [pfr_pkg::CNT_W-1:0]         r_fill_count;
    logic [pfr_pkg::FRAME_W-1:0]       r_fifo_ptr;
    logic [pfr_pkg::TOTAL_W-1:0]       r_hit_total;
    logic [pfr_pkg::TOTAL_W-1:0]       r_read_total;
    logic [pfr_pkg::TOTAL_W-1:0]       r_write_total;
    logic                              r_out_valid;
    logic                              r_hit;
    logic                              r_disk_read;
    logic                              r_disk_write;
    logic [pfr_pkg::FRAME_W-1:0]       r_frame_index;
    logic                              r_evicted_valid;
    logic [pfr_pkg::PAGE_W-1:0]        r_evicted_page;

    logic                              w_in_ready;
    logic                              w_rd_en;
    logic                              w_commit;
    logic                              w_start;
    logic [pfr_pkg::CNT_W-1:0]         w_cap;
    logic [pfr_pkg::FRAME_W-1:0]       w_ptr_eff;
    logic [pfr_pkg::FRAME_W-1:0]       w_ptr_next;
    logic                              w_hit;
    logic                              w_fill;
    logic                              w_evict;
    logic [pfr_pkg::FRAME_W-1:0]       w_frame;
    logic                              w_dread;
    logic                              w_dwrite;
    logic [pfr_pkg::PAGE_W-1:0]        w_evpage;
    logic [pfr_pkg::STAMP_W-1:0]       w_stamp;
    logic                              w_ram_we;
    pfr_pkg::t_frame_entry             w_wdata;
    pfr_pkg::t_frame_entry             w_rdata;
    pfr_pkg::t_scan_beat               w_beat;
    pfr_pkg::t_scan_res                w_res;

    // Control sequencer.
    always_comb begin
        n_state = r_state;
        case (r_state)
            pfr_pkg::ST_IDLE: begin
                if (i_valid) begin
                    n_state = pfr_pkg::ST_SCAN;
                end
            end
            pfr_pkg::ST_SCAN: begin
                if (r_idx == pfr_pkg::FRAME_W'(pfr_pkg::FRAMES - 1)) begin
                    n_state = pfr_pkg::ST_DRAIN;
                end
            end
            pfr_pkg::ST_DRAIN: begin
                n_state = pfr_pkg::ST_DECIDE;
            end
            pfr_pkg::ST_DECIDE: begin
                if (w_commit) begin
                    n_state = pfr_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = pfr_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        w_in_ready = 1'b0;
        w_rd_en    = 1'b0;
        w_commit   = 1'b0;
        case (r_state)
            pfr_pkg::ST_IDLE: begin
                w_in_ready = 1'b1;
            end
            pfr_pkg::ST_SCAN: begin
                w_rd_en = 1'b1;
            end
            pfr_pkg::ST_DRAIN: begin
                w_rd_en = 1'b0;
            end
            pfr_pkg::ST_DECIDE: begin
                w_commit = !r_out_valid || i_ready;
            end
            default: begin
                w_in_ready = 1'b0;
            end
        endcase
    end

    assign w_start = w_in_ready && i_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= pfr_pkg::ST_IDLE;
            r_idx    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= w_rd_en;
            if (w_start) begin
                r_idx <= '0;
            end else if (w_rd_en) begin
                r_idx <= r_idx + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_idx <= r_idx;
        if (w_start) begin
            r_page     <= i_address[pfr_pkg::ADDR_W-1:pfr_pkg::PAGE_SHIFT];
            r_is_write <= i_is_write;
        end
    end

    pfr_frame_ram u_frame_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_frame),
        .i_wdata (w_wdata),
        .i_raddr (r_idx),
        .o_rdata (w_rdata)
    );

    always_comb begin
        w_beat.vld         = r_rd_vld;
        w_beat.idx         = r_rd_idx;
        w_beat.frame_valid = r_frame_valid[r_rd_idx];
        w_beat.entry       = w_rdata;
    end

    pfr_scan u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_start),
        .i_beat      (w_beat),
        .i_target    (r_page),
        .i_cap       (w_cap),
        .i_probe_idx (w_ptr_eff),
        .o_res       (w_res)
    );

    // Victim selection and commit values.
    always_comb begin
        w_cap     = pfr_pkg::f_capacity(r_frames_in_use);
        w_ptr_eff = (pfr_pkg::CNT_W'(r_fifo_ptr) >= w_cap) ? '0 : r_fifo_ptr;
        w_ptr_next = ((pfr_pkg::CNT_W'(w_ptr_eff) + 1'b1) >= w_cap) ? '0 : w_ptr_eff + 1'b1;
        w_hit   = w_res.found;
        w_fill  = !w_hit && (r_fill_count < w_cap);
        w_evict = !w_hit && !w_fill;
        if (w_hit) begin
            w_frame = w_res.hit_idx;
        end else if (w_fill) begin
            w_frame = r_fill_count[pfr_pkg::FRAME_W-1:0];
        end else if (r_mode == pfr_pkg::MODE_LRU) begin
            w_frame = w_res.best_idx;
        end else begin
            w_frame = w_ptr_eff;
        end
        w_dread  = !w_hit && !r_is_write;
        w_dwrite = w_evict && r_frame_dirty[w_frame];
        if (!w_evict) begin
            w_evpage = '0;
        end else if (r_mode == pfr_pkg::MODE_LRU) begin
            w_evpage = w_res.best_page;
        end else begin
            w_evpage = w_res.probe_page;
        end
        w_stamp       = r_access_clock + 1'b1;
        w_ram_we      = w_commit && (!w_hit || (r_mode == pfr_pkg::MODE_LRU));
        w_wdata.page  = r_page;
        w_wdata.stamp = w_stamp;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode          <= pfr_pkg::MODE_LRU;
            r_frames_in_use <= pfr_pkg::FRAMES_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                pfr_pkg::CFG_REPL_MODE: begin
                    r_mode <= pfr_pkg::t_mode'(i_cfg_data[0]);
                end
                pfr_pkg::CFG_FRAMES_IN_USE: begin
                    r_frames_in_use <= i_cfg_data;
                end
                default: begin
                    r_mode <= r_mode;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_valid  <= '0;
            r_frame_dirty  <= '0;
            r_access_clock <= '0;
            r_fill_count   <= '0;
            r_fifo_ptr     <= '0;
            r_hit_total    <= '0;
            r_read_total   <= '0;
            r_write_total  <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            if (w_commit) begin
                r_out_valid    <= 1'b1;
                r_access_clock <= w_stamp;
                if (w_hit) begin
                    r_frame_dirty[w_frame] <= r_frame_dirty[w_frame] | r_is_write;
                    if (r_hit_total != '1) begin
                        r_hit_total <= r_hit_total + 1'b1;
                    end
                end else begin
                    r_frame_valid[w_frame] <= 1'b1;
                    r_frame_dirty[w_frame] <= 1'b0;
                end
                if (w_dread && (r_read_total != '1)) begin
                    r_read_total <= r_read_total + 1'b1;
                end
                if (w_dwrite && (r_write_total != '1)) begin
                    r_write_total <= r_write_total + 1'b1;
                end
                if (w_fill) begin
                    r_fill_count <= r_fill_count + 1'b1;
                end
                if (w_evict && (r_mode == pfr_pkg::MODE_FIFO)) begin
                    r_fifo_ptr <= w_ptr_next;
                end
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_commit) begin
            r_hit           <= w_hit;
            r_disk_read     <= w_dread;
            r_disk_write    <= w_dwrite;
            r_frame_index   <= w_frame;
            r_evicted_valid <= w_evict;
            r_evicted_page  <= w_evpage;
        end
    end

    assign o_ready             = w_in_ready;
    assign o_valid             = r_out_valid;
    assign o_hit               = r_hit;
    assign o_disk_read         = r_disk_read;
    assign o_disk_write        = r_disk_write;
    assign o_frame_index       = r_frame_index;
    assign o_evicted_valid     = r_evicted_valid;
    assign o_evicted_page      = r_evicted_page;
    assign o_total_hits        = r_hit_total;
    assign o_total_disk_reads  = r_read_total;
    assign o_total_disk_writes = r_write_total;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill_count <= pfr_pkg::CNT_W'(pfr_pkg::FRAMES))
        else $error("Fill count exceeds the number of frames.");

    a_miss_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_commit && !w_hit) |=> r_frame_valid[$past(w_frame)])
        else $error("A loaded frame is not marked valid.");

    a_hit_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_hit) |-> (!o_disk_read && !o_disk_write && !o_evicted_valid))
        else $error("A hit reports disk traffic or an eviction.");

    a_write_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_disk_write) |-> o_evicted_valid)
        else $error("A disk write is reported without an eviction.");

endmodule

>>> bench/tb.sv
// ============================================================================
// Page frame replacement unit testbench
// Drives memory accesses through the valid/ready channel under several
// replacement modes and frame counts, mirrors the frame table in a scoreboard
// and checks every result field against the predicted outcome.
// ============================================================================
`timescale 1ns / 100ps

module tb;

    localparam int ITEMS      = 1250;
    localparam int QUIET_ITEMS = 120;
    localparam int HOLD_AT    = 400;
    localparam int HOLD_LEN   = 500;
    localparam int PAUSE_AT   = 700;

    localparam logic [pfr_pkg::CFG_IDX_W-1:0] CFG_IDX_SPARE0 = 2'd2;
    localparam logic [pfr_pkg::CFG_IDX_W-1:0] CFG_IDX_SPARE1 = 2'd3;

    typedef struct packed {
        logic                        hit;
        logic                        disk_read;
        logic                        disk_write;
        logic [pfr_pkg::FRAME_W-1:0] frame_index;
        logic                        evicted_valid;
        logic [pfr_pkg::PAGE_W-1:0]  evicted_page;
        logic [pfr_pkg::TOTAL_W-1:0] total_hits;
        logic [pfr_pkg::TOTAL_W-1:0] total_disk_reads;
        logic [pfr_pkg::TOTAL_W-1:0] total_disk_writes;
    } t_outcome;

    class frame_scoreboard;
        pfr_pkg::t_mode                 mode;
        logic [pfr_pkg::CFG_DATA_W-1:0] frames_cfg;
        logic [pfr_pkg::PAGE_W-1:0]     page_of [pfr_pkg::FRAMES];
        bit                             resident [pfr_pkg::FRAMES];
        bit                             dirty [pfr_pkg::FRAMES];
        logic [pfr_pkg::STAMP_W-1:0]    stamp [pfr_pkg::FRAMES];
        logic [pfr_pkg::STAMP_W-1:0]    access_count;
        int unsigned                    filled;
        int unsigned                    rr_next;
        logic [pfr_pkg::TOTAL_W-1:0]    hits;
        logic [pfr_pkg::TOTAL_W-1:0]    reads;
        logic [pfr_pkg::TOTAL_W-1:0]    writes;
        t_outcome                       outcome_q[$];
        int                             errors;

        function new();
            mode = pfr_pkg::MODE_LRU;
            frames_cfg = pfr_pkg::FRAMES_RESET;
            for (int k = 0; k < pfr_pkg::FRAMES; k++) begin
                page_of[k] = '0;
                resident[k] = 1'b0;
                dirty[k] = 1'b0;
                stamp[k] = '0;
            end
            access_count = '0;
            filled = 0;
            rr_next = 0;
            hits = '0;
            reads = '0;
            writes = '0;
            errors = 0;
        endfunction

        function void write_reg(logic [pfr_pkg::CFG_IDX_W-1:0] idx,
                                logic [pfr_pkg::CFG_DATA_W-1:0] data);
            if (idx == pfr_pkg::CFG_REPL_MODE) begin
                mode = pfr_pkg::t_mode'(data[0]);
            end else if (idx == pfr_pkg::CFG_FRAMES_IN_USE) begin
                frames_cfg = data;
            end
        endfunction

        function logic [pfr_pkg::TOTAL_W-1:0] sat_bump(logic [pfr_pkg::TOTAL_W-1:0] v);
            return (v == '1) ? v : v + 1'b1;
        endfunction

        function void note_access(logic [pfr_pkg::ADDR_W-1:0] addr, logic wr);
            logic [pfr_pkg::PAGE_W-1:0] page;
            int unsigned                cap;
            int unsigned                slot;
            bit                         found;
            t_outcome                   o;
            page = addr[pfr_pkg::ADDR_W-1:pfr_pkg::PAGE_SHIFT];
            if (frames_cfg == '0) begin
                cap = 1;
            end else if (frames_cfg > pfr_pkg::FRAMES) begin
                cap = pfr_pkg::FRAMES;
            end else begin
                cap = frames_cfg;
            end
            access_count = access_count + 1'b1;
            o = '0;
            found = 1'b0;
            slot = 0;
            for (int k = 0; k < pfr_pkg::FRAMES; k++) begin
                if (!found && resident[k] && page_of[k] == page) begin
                    found = 1'b1;
                    slot = k;
                end
            end
            if (found) begin
                hits = sat_bump(hits);
                if (wr) begin
                    dirty[slot] = 1'b1;
                end
                if (mode == pfr_pkg::MODE_LRU) begin
                    stamp[slot] = access_count;
                end
            end else begin
                if (!wr) begin
                    o.disk_read = 1'b1;
                    reads = sat_bump(reads);
                end
                if (filled < cap) begin
                    slot = filled;
                    filled++;
                end else begin
                    if (mode == pfr_pkg::MODE_LRU) begin
                        slot = 0;
                        for (int k = 1; k < cap; k++) begin
                            if (stamp[k] < stamp[slot]) begin
                                slot = k;
                            end
                        end
                    end else begin
                        if (rr_next >= cap) begin
                            rr_next = 0;
                        end
                        slot = rr_next;
                        rr_next = (rr_next + 1 >= cap) ? 0 : rr_next + 1;
                    end
                    o.evicted_valid = 1'b1;
                    o.evicted_page = page_of[slot];
                    if (dirty[slot]) begin
                        o.disk_write = 1'b1;
                        writes = sat_bump(writes);
                    end
                end
                page_of[slot] = page;
                resident[slot] = 1'b1;
                dirty[slot] = 1'b0;
                stamp[slot] = access_count;
            end
            o.hit = found;
            o.frame_index = slot[pfr_pkg::FRAME_W-1:0];
            o.total_hits = hits;
            o.total_disk_reads = reads;
            o.total_disk_writes = writes;
            outcome_q.push_back(o);
        endfunction

        function void cmp_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
            if (exp_v !== act_v) begin
                $error("%s: expected %0h, got %0h", name, exp_v, act_v);
                errors++;
            end
        endfunction

        function void check_result(t_outcome got);
            t_outcome want;
            if (outcome_q.size() == 0) begin
                $error("result item with no access waiting");
                errors++;
            end else begin
                want = outcome_q.pop_front();
                cmp_field("hit", want.hit, got.hit);
                cmp_field("disk_read", want.disk_read, got.disk_read);
                cmp_field("disk_write", want.disk_write, got.disk_write);
                cmp_field("frame_index", want.frame_index, got.frame_index);
                cmp_field("evicted_valid", want.evicted_valid, got.evicted_valid);
                cmp_field("evicted_page", want.evicted_page, got.evicted_page);
                cmp_field("total_hits", want.total_hits, got.total_hits);
                cmp_field("total_disk_reads", want.total_disk_reads, got.total_disk_reads);
                cmp_field("total_disk_writes", want.total_disk_writes,
                          got.total_disk_writes);
            end
        endfunction
    endclass

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           i_valid;
    logic                           o_ready;
    logic [pfr_pkg::ADDR_W-1:0]     i_address;
    logic                           i_is_write;
    logic                           o_valid;
    logic                           i_ready;
    logic                           o_hit;
    logic                           o_disk_read;
    logic                           o_disk_write;
    logic [pfr_pkg::FRAME_W-1:0]    o_frame_index;
    logic                           o_evicted_valid;
    logic [pfr_pkg::PAGE_W-1:0]     o_evicted_page;
    logic [pfr_pkg::TOTAL_W-1:0]    o_total_hits;
    logic [pfr_pkg::TOTAL_W-1:0]    o_total_disk_reads;
    logic [pfr_pkg::TOTAL_W-1:0]    o_total_disk_writes;
    logic                           i_cfg_we;
    logic [pfr_pkg::CFG_IDX_W-1:0]  i_cfg_idx;
    logic [pfr_pkg::CFG_DATA_W-1:0] i_cfg_data;

    frame_scoreboard sb;
    int              sent;
    int              results_seen;
    bit              quiet;

    page_frame_replacement_unit u_top (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (i_valid),
        .o_ready             (o_ready),
        .i_address           (i_address),
        .i_is_write          (i_is_write),
        .o_valid             (o_valid),
        .i_ready             (i_ready),
        .o_hit               (o_hit),
        .o_disk_read         (o_disk_read),
        .o_disk_write        (o_disk_write),
        .o_frame_index       (o_frame_index),
        .o_evicted_valid     (o_evicted_valid),
        .o_evicted_page      (o_evicted_page),
        .o_total_hits        (o_total_hits),
        .o_total_disk_reads  (o_total_disk_reads),
        .o_total_disk_writes (o_total_disk_writes),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_idx           (i_cfg_idx),
        .i_cfg_data          (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    task automatic send_access(input logic [pfr_pkg::ADDR_W-1:0] addr, input logic wr);
        @(negedge i_clk);
        i_valid <= 1'b1;
        i_address <= addr;
        i_is_write <= wr;
        do @(posedge i_clk); while (!o_ready);
        sb.note_access(addr, wr);
        sent++;
    endtask

    task automatic sender_gap();
        int n;
        if (!quiet && $urandom_range(0, 7) == 0) begin
            n = $urandom_range(1, 6);
            @(negedge i_clk);
            i_valid <= 1'b0;
            repeat (n - 1) @(negedge i_clk);
        end
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (sb.outcome_q.size() != 0) @(posedge i_clk);
        repeat (2) @(negedge i_clk);
    endtask

    task automatic cfg_write(input logic [pfr_pkg::CFG_IDX_W-1:0] idx,
                             input logic [pfr_pkg::CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        sb.write_reg(idx, data);
    endtask

    initial begin
        int          hold_left;
        int          idle_left;
        bit          held_once;
        hold_left = 0;
        idle_left = 0;
        held_once = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && i_ready) begin
                sb.check_result(t_outcome'{o_hit, o_disk_read, o_disk_write, o_frame_index,
                                           o_evicted_valid, o_evicted_page, o_total_hits,
                                           o_total_disk_reads, o_total_disk_writes});
                results_seen++;
            end
            @(negedge i_clk);
            if (!held_once && results_seen >= HOLD_AT) begin
                held_once = 1'b1;
                hold_left = HOLD_LEN;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else if (idle_left > 0) begin
                idle_left--;
                i_ready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                idle_left = $urandom_range(1, 6) - 1;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    initial begin
        #5000000;
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        logic [pfr_pkg::PAGE_W-1:0] pool [0:127];
        int                         pool_size;
        int                         cap;
        int                         burst;
        int                         pick;
        bit                         paused;
        logic [pfr_pkg::PAGE_W-1:0] page;
        logic [6:0]                 frames_pick;
        logic                       mode_pick;

        sb = new();
        sent = 0;
        results_seen = 0;
        quiet = 1'b0;
        paused = 1'b0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_address = '0;
        i_is_write = 1'b0;
        i_ready = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // A zero frame count behaves as a single frame.
        cfg_write(pfr_pkg::CFG_REPL_MODE, {6'd0, pfr_pkg::MODE_LRU});
        cfg_write(pfr_pkg::CFG_FRAMES_IN_USE, 7'd0);
        send_access(32'h0000_0000, 1'b0);
        send_access(32'hFFFF_FFFF, 1'b1);
        send_access(32'hFFFF_F123, 1'b1);
        send_access(32'h1234_5678, 1'b0);
        send_access(32'h1234_5000, 1'b0);
        wait_drained();

        // Writes to unused indexes must be ignored.
        cfg_write(CFG_IDX_SPARE0, 7'h7F);
        cfg_write(CFG_IDX_SPARE1, 7'h00);
        cfg_write(pfr_pkg::CFG_REPL_MODE, {6'h3F, pfr_pkg::MODE_FIFO});
        cfg_write(pfr_pkg::CFG_FRAMES_IN_USE, 7'd3);
        send_access(32'h0000_1000, 1'b0);
        send_access(32'h0000_2000, 1'b0);
        send_access(32'h0000_3000, 1'b0);
        send_access(32'h0000_1ABC, 1'b1);
        send_access(32'h0000_4000, 1'b0);
        wait_drained();

        // Lowered count: upper frames still hit, and the round-robin pointer wraps.
        cfg_write(pfr_pkg::CFG_FRAMES_IN_USE, 7'd1);
        send_access(32'h0000_3000, 1'b0);
        send_access(32'h0000_2FFF, 1'b0);
        send_access(32'h0000_6000, 1'b1);
        wait_drained();

        cfg_write(pfr_pkg::CFG_REPL_MODE, {6'd0, pfr_pkg::MODE_LRU});
        cfg_write(pfr_pkg::CFG_FRAMES_IN_USE, 7'd100);
        send_access(32'hFFFF_F000, 1'b0);
        send_access(32'h0000_2000, 1'b0);
        send_access(32'h8000_0000, 1'b1);
        wait_drained();

        cfg_write(pfr_pkg::CFG_FRAMES_IN_USE, 7'd2);
        send_access(32'h0009_0000, 1'b0);
        send_access(32'h000A_0000, 1'b0);
        send_access(32'h0009_0FFF, 1'b1);
        send_access(32'h000B_0000, 1'b0);
        wait_drained();

        while (sent < ITEMS) begin
            mode_pick = $urandom_range(0, 1);
            case ($urandom_range(0, 9))
                0: frames_pick = 7'd0;
                1: frames_pick = 7'd1;
                2: frames_pick = 7'd64;
                3: frames_pick = 7'($urandom_range(65, 127));
                4: frames_pick = 7'd127;
                5, 6: frames_pick = 7'($urandom_range(2, 8));
                default: frames_pick = 7'($urandom_range(1, 64));
            endcase
            cap = (frames_pick == 0) ? 1 :
                  ((frames_pick > pfr_pkg::FRAMES) ? pfr_pkg::FRAMES : frames_pick);
            wait_drained();
            cfg_write(pfr_pkg::CFG_REPL_MODE, {6'($urandom), mode_pick});
            cfg_write(pfr_pkg::CFG_FRAMES_IN_USE, frames_pick);
            if ($urandom_range(0, 7) == 0) begin
                cfg_write($urandom_range(0, 1) ? CFG_IDX_SPARE0 : CFG_IDX_SPARE1,
                          7'($urandom));
            end
            pool_size = $urandom_range(1, cap + cap / 2 + 4);
            for (int k = 0; k < pool_size; k++) begin
                pool[k] = pfr_pkg::PAGE_W'($urandom);
            end
            burst = $urandom_range(30, 120);
            for (int k = 0; k < burst && sent < ITEMS; k++) begin
                if (!paused && sent >= PAUSE_AT) begin
                    paused = 1'b1;
                    wait_drained();
                end
                if (sent >= ITEMS - QUIET_ITEMS) begin
                    quiet = 1'b1;
                end
                pick = $urandom_range(0, 19);
                if (pick < 18) begin
                    page = pool[$urandom_range(0, pool_size - 1)];
                end else if (pick == 18) begin
                    page = pfr_pkg::PAGE_W'($urandom);
                end else begin
                    page = $urandom_range(0, 1) ? '1 : '0;
                end
                sender_gap();
                send_access({page, 12'($urandom)}, 1'($urandom));
            end
        end

        @(negedge i_clk);
        i_valid <= 1'b0;
        while (sb.outcome_q.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (sb.errors == 0 && sb.outcome_q.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

>>> page_frame_replacement_unit.f
hw/rtl/pfr_pkg.sv
hw/rtl/pfr_frame_ram.sv
hw/rtl/pfr_scan.sv
hw/rtl/page_frame_replacement_unit.sv
bench/tb.sv
